// ----- hdl/sgdm_pkg.sv -----
// Package for the SGD momentum update block: word types, sizes, register
// indexes and the command and status bundles between controller and datapath.
// No dependencies.
package sgdm_pkg;

  // Velocity store size and its address width.
  localparam int VelDepth = 4096;
  localparam int VelAw    = (VelDepth > 1) ? $clog2(VelDepth) : 1;

  localparam int CoefW = 24;
  localparam int ValW  = 32;

  // Configuration register indexes.
  localparam logic [1:0] RegLearningRate   = 2'd0;
  localparam logic [1:0] RegMomentumFactor = 2'd1;
  localparam logic [1:0] RegDecayFactor    = 2'd2;

  typedef struct packed {
    logic [11:0]            element_index;
    logic signed [ValW-1:0] param_value;
    logic signed [ValW-1:0] grad_value;
    logic                   grad_present;
  } sgdm_in_t;

  typedef struct packed {
    logic signed [ValW-1:0] new_param;
    logic                   overflow;
  } sgdm_out_t;

  // Operand pair fed to the shared multiplier.
  typedef enum logic [1:0] {
    MulDecay    = 2'd0,
    MulMomentum = 2'd1,
    MulRate     = 2'd2
  } mul_sel_e;

  typedef struct packed {
    logic     clr;       // write zero at the clearing address, advance it
    logic     latch;     // capture the input word and read the velocity
    logic     mul_en;    // register one product
    mul_sel_e mul_sel;
    logic     g_en;      // register the effective gradient
    logic     v_en;      // register and store the new velocity
    logic     out_load;  // load the result word
  } sgdm_cmd_t;

  typedef struct packed {
    logic present;       // captured word carries a gradient
    logic mom_on;        // momentum factor is nonzero
    logic clr_last;      // clearing address is at the last entry
  } sgdm_sts_t;

endpackage

// ----- hdl/sgdm_ctrl.sv -----
// Controller of the SGD momentum update block: sequences the clearing pass,
// the multiply and sum steps of one word, and the output word register.
// Depends on sgdm_pkg.
module sgdm_ctrl import sgdm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  sgdm_sts_t sts_i,
  output sgdm_cmd_t cmd_o
);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StMulD  = 3'd2;
  localparam logic [2:0] StSumG  = 3'd3;
  localparam logic [2:0] StMulM  = 3'd4;
  localparam logic [2:0] StSumV  = 3'd5;
  localparam logic [2:0] StMulL  = 3'd6;
  localparam logic [2:0] StRes   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  // The result register can take a new word when empty or being drained.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.mul_sel = MulDecay;
    in_stall_o    = 1'b1;
    case (state_q)
      StClear: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = StMulD;
        end
      end
      StMulD: begin
        if (sts_i.present) begin
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MulDecay;
          state_d       = StSumG;
        end else begin
          state_d = StRes;
        end
      end
      StSumG: begin
        cmd_o.g_en = 1'b1;
        state_d    = sts_i.mom_on ? StMulM : StMulL;
      end
      StMulM: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulMomentum;
        state_d       = StSumV;
      end
      StSumV: begin
        cmd_o.v_en = 1'b1;
        state_d    = StMulL;
      end
      StMulL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MulRate;
        state_d       = StRes;
      end
      StRes: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/sgdm_datapath.sv -----
// Datapath of the SGD momentum update block: coefficient registers, velocity
// memory, one shared multiplier, round-add-saturate logic and the result word.
// Depends on sgdm_pkg.
module sgdm_datapath import sgdm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [CoefW-1:0]  cfg_data_i,
  input  sgdm_in_t          in_word_i,
  input  sgdm_cmd_t         cmd_i,
  output sgdm_sts_t         sts_o,
  output sgdm_out_t         out_word_o
);

  typedef struct packed {
    logic               ovf;
    logic signed [31:0] val;
  } sat_t;

  // Clamp a 34-bit sum to the signed 32-bit range.
  function automatic sat_t sat32(input logic signed [33:0] x);
    sat_t r;
    r.ovf = !((x[33:31] == 3'b000) || (x[33:31] == 3'b111));
    r.val = r.ovf ? (x[33] ? 32'sh8000_0000 : 32'sh7fff_ffff) : x[31:0];
    return r;
  endfunction

  logic [CoefW-1:0] lr_q, mom_q, decay_q;

  sgdm_in_t           in_q;
  logic               in_range_q;
  logic [31:0]        vel_mem [VelDepth];
  logic [31:0]        vrd_q;
  logic [VelAw-1:0]   clr_addr_q;

  logic [CoefW-1:0]   mul_a;
  logic signed [31:0] mul_b;
  logic signed [56:0] prod_d, prod_q;
  logic signed [56:0] rnd_full;
  logic signed [32:0] rnd;

  logic signed [31:0] g_q, v_q;
  logic               ovf_q;
  sat_t               g_sat, v_sat, res_sat;
  sgdm_out_t          out_q;

  // Coefficient registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= '0;
      mom_q   <= '0;
      decay_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegLearningRate:   lr_q    <= cfg_data_i;
        RegMomentumFactor: mom_q   <= cfg_data_i;
        RegDecayFactor:    decay_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Clearing address walks the velocity memory once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clr) begin
      clr_addr_q <= clr_addr_q + VelAw'(1);
    end
  end

  // Captured input word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      in_q       <= in_word_i;
      in_range_q <= 32'(in_word_i.element_index) < 32'(VelDepth);
    end
  end

  // Velocity memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      vel_mem[clr_addr_q] <= '0;
    end else if (cmd_i.v_en && in_range_q) begin
      vel_mem[VelAw'(in_q.element_index)] <= v_sat.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      vrd_q <= vel_mem[VelAw'(in_word_i.element_index)];
    end
  end

  // Shared multiplier: unsigned Q0.24 coefficient times signed Q16.16 value.
  always_comb begin
    case (cmd_i.mul_sel)
      MulDecay: begin
        mul_a = decay_q;
        mul_b = in_q.param_value;
      end
      MulMomentum: begin
        mul_a = mom_q;
        mul_b = in_range_q ? $signed(vrd_q) : 32'sd0;
      end
      MulRate: begin
        mul_a = lr_q;
        mul_b = sts_o.mom_on ? v_q : g_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = $signed({1'b0, mul_a}) * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  // Round half up to Q16.16: add one half and drop 24 fraction bits.
  assign rnd_full = prod_q + 57'sd8388608;
  assign rnd      = rnd_full[56:24];

  assign g_sat   = sat32({{2{in_q.grad_value[31]}}, in_q.grad_value} + {rnd[32], rnd});
  assign v_sat   = sat32({rnd[32], rnd} + {{2{g_q[31]}}, g_q});
  assign res_sat = sat32({{2{in_q.param_value[31]}}, in_q.param_value} - {rnd[32], rnd});

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      ovf_q <= 1'b0;
    end else if (cmd_i.g_en) begin
      ovf_q <= g_sat.ovf;
    end else if (cmd_i.v_en) begin
      ovf_q <= ovf_q | v_sat.ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.g_en) begin
      g_q <= g_sat.val;
    end
    if (cmd_i.v_en) begin
      v_q <= v_sat.val;
    end
  end

  // Result word; a word without a gradient passes its parameter through.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      if (in_q.grad_present) begin
        out_q.new_param <= res_sat.val;
        out_q.overflow  <= ovf_q | res_sat.ovf;
      end else begin
        out_q.new_param <= in_q.param_value;
        out_q.overflow  <= 1'b0;
      end
    end
  end

  assign sts_o.present  = in_q.grad_present;
  assign sts_o.mom_on   = (mom_q != '0);
  assign sts_o.clr_last = (clr_addr_q == VelAw'(VelDepth - 1));
  assign out_word_o     = out_q;

endmodule

// ----- hdl/sgd_momentum_update.sv -----
// Top level of the SGD momentum update block: controller plus datapath.
// Depends on sgdm_pkg, sgdm_ctrl and sgdm_datapath.
//
// Each input word carries one parameter element, its gradient, a
// gradient-present flag and the element's index into a 4096-entry velocity
// memory; each word yields exactly one result word with the updated parameter
// (signed Q16.16, saturated) and an overflow flag that is set if the
// effective gradient, the velocity or the parameter saturated. Coefficients
// (learning rate, momentum, weight decay) are unsigned Q0.24 and are written
// through the plain write port; the user must write them only while the
// block is idle, which the block itself does not enforce. After reset the
// block clears the velocity memory one entry per cycle, so in_stall_o stays
// high until every entry is cleared. Words are processed one at a time by a
// small sequencer around a single 25x32 multiplier: the decay, momentum and
// learning-rate products are each registered in a multiplier step followed
// by a round-add-saturate step. A word with a gradient and nonzero momentum
// goes through decay multiply, gradient sum, momentum multiply, velocity sum,
// rate multiply and result load; zero momentum skips the momentum multiply
// and velocity sum, and a word without a gradient goes straight to the load.
// Results sit in an output register, so the next word is accepted while the
// previous result is still waiting to be taken; out_stall_i only holds the
// block once a finished result finds that register still full.
module sgd_momentum_update import sgdm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CoefW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sgdm_in_t         in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sgdm_out_t        out_word_o
);

  sgdm_cmd_t cmd;
  sgdm_sts_t sts;

  // Sequencer: clearing pass, per-word step order and output handshake.
  sgdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic, coefficient registers and the velocity memory.
  sgdm_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule
